### hdl/bcd_pkg.sv
`timescale 1ns / 1ps
// bcd_pkg: types, codes and small arithmetic helpers for the block decoder
// used by bcd_front, bcd_queue, bcd_back and bc_texture_block_decoder_top
package bcd_pkg;

    localparam int COORD_BITS = 14;
    localparam int CFG_DATA_W = 15;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // reciprocal constants for exact truncating divides over the value ranges used
    localparam int K_DIV3 = 683;   // x <= 765,  >> 11
    localparam int K_DIV5 = 1639;  // x <= 1275, >> 13
    localparam int K_DIV7 = 2341;  // x <= 1785, >> 14

    typedef enum logic [1:0] {
        FMT_DXT1 = 2'd0,
        FMT_DXT3 = 2'd1,
        FMT_DXT5 = 2'd2
    } t_fmt;

    typedef enum logic [1:0] {
        REG_FORMAT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg;

    typedef struct packed {
        logic [63:0] alpha_bits;
        logic [63:0] color_bits;
        logic [11:0] block_x;
        logic [11:0] block_y;
    } t_bcd_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_row_y;
        logic [COORD_BITS-1:0] pixel_col_x;
        logic [31:0]           texel_0;
        logic [31:0]           texel_1;
        logic [31:0]           texel_2;
        logic [31:0]           texel_3;
        logic [3:0]            valid_mask;
        logic                  last_row;
    } t_bcd_out;

    typedef struct packed {
        logic [1:0]            texture_format;
        logic [CFG_DATA_W-1:0] image_width;
        logic [CFG_DATA_W-1:0] image_height;
    } t_bcd_cfg;

    // one decoded block waiting for row emission
    typedef struct packed {
        logic [3:0][31:0] pal;     // color palette, rgba
        logic [31:0]      cidx;    // 2-bit color indices
        logic [7:0][7:0]  atab;    // dxt5 alpha table
        logic [63:0]      abits;   // raw alpha half
        logic             is_dxt3;
        logic             is_dxt5;
        logic [11:0]      block_x;
        logic [11:0]      block_y;
    } t_bcd_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_bcd_qstat;

    // 5-bit channel to 8 bits: v*255/31 = 8v + floor(7v/31)
    function automatic logic [7:0] exp5(input logic [4:0] v);
        logic [7:0] x7;
        logic [2:0] q;
        x7 = 8'(v) * 8'd7;
        q  = 3'd0;
        for (int k = 1; k <= 7; k++) begin
            if (x7 >= 8'(31 * k)) q = q + 3'd1;
        end
        return {v, 3'b000} + 8'(q);
    endfunction

    // 6-bit channel to 8 bits: v*255/63 = 4v + floor(v/21)
    function automatic logic [7:0] exp6(input logic [5:0] v);
        logic [1:0] q;
        q = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
        return {v, 2'b00} + 8'(q);
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'(K_DIV3);
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'(K_DIV5);
        return p[20:13];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'(K_DIV7);
        return p[21:14];
    endfunction

endpackage

### hdl/bcd_front.sv
`timescale 1ns / 1ps
// bcd_front: accepts a block, expands endpoints, then builds color and alpha palettes
// depends on bcd_pkg; feeds bcd_queue
module bcd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  bcd_pkg::t_bcd_in    i_item,
    input  bcd_pkg::t_bcd_cfg   i_cfg,
    input  bcd_pkg::t_bcd_qstat i_qstat,
    output logic                o_push,
    output bcd_pkg::t_bcd_entry o_entry
);

    typedef struct packed {
        logic [2:0][7:0] e0;     // expanded c0, b g r
        logic [2:0][7:0] e1;     // expanded c1
        logic            c0_gt;
        logic            is_dxt3;
        logic            is_dxt5;
        logic [31:0]     cidx;
        logic [63:0]     abits;
        logic [11:0]     block_x;
        logic [11:0]     block_y;
    } t_bcd_s1;

    logic    r_s1_valid;
    t_bcd_s1 r_s1;
    t_bcd_s1 n_s1;
    logic    accept;

    logic [15:0] c0;
    logic [15:0] c1;
    logic [7:0]  a0;
    logic [7:0]  a1;

    function automatic logic [7:0] exp_b(input logic [15:0] c);
        return bcd_pkg::exp5(c[4:0]);
    endfunction

    assign o_push = r_s1_valid && !i_qstat.full;
    assign o_busy = r_s1_valid && i_qstat.full;
    assign accept = i_start && !o_busy;

    // stage one: endpoint expansion and format decode
    always_comb begin
        c0 = i_item.color_bits[15:0];
        c1 = i_item.color_bits[31:16];
        n_s1.e0      = {exp_b(c0), bcd_pkg::exp6(c0[10:5]), bcd_pkg::exp5(c0[15:11])};
        n_s1.e1      = {exp_b(c1), bcd_pkg::exp6(c1[10:5]), bcd_pkg::exp5(c1[15:11])};
        n_s1.c0_gt   = c0 > c1;
        n_s1.is_dxt3 = i_cfg.texture_format == bcd_pkg::FMT_DXT3;
        n_s1.is_dxt5 = i_cfg.texture_format == bcd_pkg::FMT_DXT5;
        n_s1.cidx    = i_item.color_bits[63:32];
        n_s1.abits   = i_item.alpha_bits;
        n_s1.block_x = i_item.block_x;
        n_s1.block_y = i_item.block_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // stage two: palette interpolation
    always_comb begin
        logic three_col;
        logic [2:0][7:0] p2;
        logic [2:0][7:0] p3;
        three_col = !r_s1.is_dxt3 && !r_s1.is_dxt5 && !r_s1.c0_gt;
        for (int ch = 0; ch < 3; ch++) begin
            if (three_col) begin
                p2[ch] = 8'((9'(r_s1.e0[ch]) + 9'(r_s1.e1[ch])) >> 1);
                p3[ch] = 8'd0;
            end else begin
                p2[ch] = bcd_pkg::div3({1'b0, r_s1.e0[ch], 1'b0} + 10'(r_s1.e1[ch]));
                p3[ch] = bcd_pkg::div3(10'(r_s1.e0[ch]) + {1'b0, r_s1.e1[ch], 1'b0});
            end
        end
        o_entry.pal[0] = {8'hFF, r_s1.e0};
        o_entry.pal[1] = {8'hFF, r_s1.e1};
        o_entry.pal[2] = {8'hFF, p2};
        o_entry.pal[3] = {three_col ? 8'h00 : 8'hFF, p3};

        a0 = r_s1.abits[7:0];
        a1 = r_s1.abits[15:8];
        o_entry.atab[0] = a0;
        o_entry.atab[1] = a1;
        if (a0 > a1) begin
            for (int i = 1; i <= 6; i++) begin
                o_entry.atab[i+1] = bcd_pkg::div7(11'((7 - i) * a0) + 11'(i * a1));
            end
        end else begin
            for (int i = 1; i <= 4; i++) begin
                o_entry.atab[i+1] = bcd_pkg::div5(11'((5 - i) * a0) + 11'(i * a1));
            end
            o_entry.atab[6] = 8'd0;
            o_entry.atab[7] = 8'd255;
        end

        o_entry.cidx    = r_s1.cidx;
        o_entry.abits   = r_s1.abits;
        o_entry.is_dxt3 = r_s1.is_dxt3;
        o_entry.is_dxt5 = r_s1.is_dxt5;
        o_entry.block_x = r_s1.block_x;
        o_entry.block_y = r_s1.block_y;
    end

endmodule

### hdl/bcd_queue.sv
`timescale 1ns / 1ps
// bcd_queue: short fifo of decoded blocks between front and back
// depends on bcd_pkg
module bcd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bcd_pkg::t_bcd_entry i_push_entry,
    input  logic                i_pop,
    output bcd_pkg::t_bcd_entry o_pop_entry,
    output bcd_pkg::t_bcd_qstat o_qstat
);

    bcd_pkg::t_bcd_entry r_mem [bcd_pkg::QDEPTH];
    logic [bcd_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [bcd_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [bcd_pkg::QCNT_W-1:0] r_count;

    assign o_qstat.full  = r_count == bcd_pkg::QCNT_W'(bcd_pkg::QDEPTH);
    assign o_qstat.empty = r_count == '0;
    assign o_pop_entry   = r_mem[r_rd_ptr];

    function automatic logic [bcd_pkg::QPTR_W-1:0] ptr_inc(
        input logic [bcd_pkg::QPTR_W-1:0] p
    );
        return (p == bcd_pkg::QPTR_W'(bcd_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

### hdl/bcd_back.sv
`timescale 1ns / 1ps
// bcd_back: emits the four pixel rows of each queued block, one row a cycle
// depends on bcd_pkg; reads bcd_queue
module bcd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bcd_pkg::t_bcd_cfg   i_cfg,
    input  bcd_pkg::t_bcd_qstat i_qstat,
    input  bcd_pkg::t_bcd_entry i_entry,
    output logic                o_pop,
    output logic                o_result_valid,
    output bcd_pkg::t_bcd_out   o_result
);

    logic                r_active;
    logic [1:0]          r_row;
    bcd_pkg::t_bcd_entry r_cur;
    bcd_pkg::t_bcd_out   n_result;
    logic                last;

    assign last  = r_row == 2'd3;
    assign o_pop = !i_qstat.empty && (!r_active || last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_row    <= 2'd0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_row    <= 2'd0;
        end else if (r_active) begin
            r_active <= !last;
            r_row    <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
    end

    // row assembly
    always_comb begin
        logic [3:0][31:0] tex;
        logic [3:0]       p;
        logic [1:0]       ci;
        logic [7:0]       alpha;
        logic [3:0]       nib;
        logic [2:0]       ai;
        logic [14:0]      col_x;
        logic [14:0]      row_y;
        logic [3:0]       mask;
        row_y = 15'({r_cur.block_y, r_row});
        for (int k = 0; k < 4; k++) begin
            p     = {r_row, 2'(k)};
            ci    = r_cur.cidx[2*p +: 2];
            nib   = r_cur.abits[4*p +: 4];
            ai    = r_cur.abits[16 + 3*p +: 3];
            if (r_cur.is_dxt3) begin
                alpha = {nib, nib};
            end else if (r_cur.is_dxt5) begin
                alpha = r_cur.atab[ai];
            end else begin
                alpha = r_cur.pal[ci][31:24];
            end
            tex[k]  = {alpha, r_cur.pal[ci][23:0]};
            col_x   = 15'({r_cur.block_x, 2'b00}) + 15'(k);
            mask[k] = (col_x < i_cfg.image_width) && (row_y < i_cfg.image_height);
        end
        n_result.pixel_row_y = bcd_pkg::COORD_BITS'({r_cur.block_y, r_row});
        n_result.pixel_col_x = bcd_pkg::COORD_BITS'({r_cur.block_x, 2'b00});
        n_result.texel_0     = tex[0];
        n_result.texel_1     = tex[1];
        n_result.texel_2     = tex[2];
        n_result.texel_3     = tex[3];
        n_result.valid_mask  = mask;
        n_result.last_row    = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_result;
    end

endmodule

### hdl/bc_texture_block_decoder_top.sv
`timescale 1ns / 1ps
// bc_texture_block_decoder_top: dxt1/dxt3/dxt5 4x4 block decoder, one pixel row per result
// depends on bcd_pkg, bcd_front, bcd_queue, bcd_back
//
//  channel   | signals                                     | handshake
//  ----------+---------------------------------------------+--------------------------
//  block in  | start, busy, i_item                         | word taken on start & !busy
//  row out   | o_result_valid, o_result                    | no stall
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index/data  | write on valid & ready
//
// each block yields four row words on consecutive cycles; a new block can be taken
// every cycle until the two-entry queue and the front register fill; sustained rate
// is set by the single row port. the first row word reaches the ports through expand,
// interpolate, load and the output register. synchronous active-low reset clears
// control state; config returns to dxt1, 256 x 256. busy rises only with the queue
// full and the front holding a block.
module bc_texture_block_decoder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bcd_pkg::t_bcd_in               i_item,
    output logic                           o_result_valid,
    output bcd_pkg::t_bcd_out              o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [bcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    bcd_pkg::t_bcd_cfg   r_cfg;
    bcd_pkg::t_bcd_qstat qstat;
    bcd_pkg::t_bcd_entry push_entry;
    bcd_pkg::t_bcd_entry pop_entry;
    logic                q_push;
    logic                q_pop;

    // config registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.texture_format <= bcd_pkg::FMT_DXT1;
            r_cfg.image_width    <= bcd_pkg::CFG_DATA_W'(256);
            r_cfg.image_height   <= bcd_pkg::CFG_DATA_W'(256);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bcd_pkg::REG_FORMAT: r_cfg.texture_format <= i_cfg_data[1:0];
                bcd_pkg::REG_WIDTH:  r_cfg.image_width    <= i_cfg_data;
                bcd_pkg::REG_HEIGHT: r_cfg.image_height   <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // front: accept, endpoint expansion, palette build
    bcd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .i_qstat (qstat),
        .o_push  (q_push),
        .o_entry (push_entry)
    );

    // decoded blocks wait here while the back side walks rows
    bcd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_entry (push_entry),
        .i_pop        (q_pop),
        .o_pop_entry  (pop_entry),
        .o_qstat      (qstat)
    );

    // back: row sequencer, texel select, bounds mask
    bcd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_qstat        (qstat),
        .i_entry        (pop_entry),
        .o_pop          (q_pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // front must never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !qstat.full)
        else $error("push into full block queue");

    // rows of one block come out on consecutive cycles
    a_rows_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.last_row) |=> o_result_valid)
        else $error("row word sequence broken before last row");

    // last flag sits on the fourth pixel row of the block
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.last_row == (o_result.pixel_row_y[1:0] == 2'b11)))
        else $error("last_row does not match row position");

    // the queue is never popped empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !qstat.empty)
        else $error("pop from empty block queue");

endmodule
